// ===== design/utrq_pkg.sv =====
// Shared types and constants for the UART transmit ring queue.
// No dependencies; imported by utrq_ctrl, utrq_datapath and the top level.
package utrq_pkg;

  // Field and register widths
  localparam int LEVEL_W    = 4;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int BUF_SIZE_W = 9;
  localparam int TRIGGER_W  = 4;
  localparam int COUNT_W    = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLLED_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIFO_TRIGGER = 2'd2;

  // Register reset values
  localparam logic [BUF_SIZE_W-1:0] BUFFER_SIZE_RESET  = 9'd256;
  localparam logic [TRIGGER_W-1:0]  FIFO_TRIGGER_RESET = 4'd4;

  // Hardware FIFO depth and the longest burst of one drain
  localparam logic [LEVEL_W-1:0] FIFO_DEPTH = 4'd8;
  localparam logic [COUNT_W-1:0] MAX_BURST  = 4'd8;

  // Input function codes
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Reply kinds
  localparam logic REPLY_PUSH  = 1'b0;
  localparam logic REPLY_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_EMIT
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_in;      // capture the input beat
    logic commit_reply;  // finish a push or a drain that sends nothing
    logic read_issue;    // read the store at the read index
    logic emit_byte;     // send the byte just read
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_push;       // latched item is a push
    logic no_send;       // latched drain sends no byte
    logic slot_free;     // output register can take a beat
    logic fin;           // byte being sent ends the burst
  } dp_status_t;

endpackage

// ===== design/utrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/utrq_ctrl.sv =====
// Controller state machine of the UART transmit ring queue.
// Depends on utrq_pkg; drives commands into utrq_datapath.
module utrq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  utrq_pkg::dp_status_t status,
  output utrq_pkg::ctrl_cmd_t  cmd
);
  import utrq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // Hold off input beats while reset is applied
        in_ready = !rst;
        if (in_valid && in_ready) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.is_push || status.no_send) begin
          if (status.slot_free) begin
            cmd.commit_reply = 1'b1;
            state_next       = ST_IDLE;
          end
        end else begin
          cmd.read_issue = 1'b1;
          state_next     = ST_EMIT;
        end
      end
      ST_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_byte = 1'b1;
          state_next    = status.fin ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A read is always followed by a send attempt
  assert property (@(posedge clk) disable iff (rst)
    cmd.read_issue |=> state == ST_EMIT)
    else $error("read not followed by emit state");

endmodule

// ===== design/utrq_datapath.sv =====
// Datapath of the UART transmit ring queue: registers, indices, store and output stage.
// Depends on utrq_pkg and utrq_ram; commanded by utrq_ctrl.
module utrq_datapath #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input beat
  input  logic                                  func,
  input  logic [utrq_pkg::BYTE_W-1:0]           data_byte,
  input  logic [utrq_pkg::LEVEL_W-1:0]          fifo_level,
  // configuration
  input  logic                                  cfg_we,
  input  logic [utrq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [utrq_pkg::CFG_DATA_W-1:0]       cfg_data,
  // output beat
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  reply_kind,
  output logic                                  accepted,
  output logic                                  byte_valid,
  output logic [utrq_pkg::BYTE_W-1:0]           tx_byte,
  output logic                                  last,
  output logic                                  tx_active,
  output logic                                  tx_irq_enable,
  // control
  input  utrq_pkg::ctrl_cmd_t                   cmd,
  output utrq_pkg::dp_status_t                  status
);
  import utrq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam logic [BUF_SIZE_W-1:0] QDEPTH = BUF_SIZE_W'(QUEUE_DEPTH);

  // Configuration registers
  logic [BUF_SIZE_W-1:0] buffer_size;
  logic                  polled_mode;
  logic [TRIGGER_W-1:0]  fifo_trigger;

  // Queue state
  logic [IW-1:0] read_index;
  logic [IW-1:0] write_index;
  logic          active_flag;

  // Latched input beat and burst count
  logic                func_q;
  logic [BYTE_W-1:0]   data_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [COUNT_W-1:0]  count;

  logic [BYTE_W-1:0]     rd_data;
  logic [BUF_SIZE_W-1:0] ring_len;
  logic [BUF_SIZE_W-1:0] wr_sum;
  logic [BUF_SIZE_W-1:0] rd_sum;
  logic [IW-1:0]         wr_adv;
  logic [IW-1:0]         rd_adv;
  logic                  full;
  logic                  empty;
  logic                  drain_ok;
  logic [COUNT_W-1:0]    room;
  logic                  store_we;
  logic                  active_nosend;
  logic                  active_emit;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size  <= BUFFER_SIZE_RESET;
      polled_mode  <= 1'b0;
      fifo_trigger <= FIFO_TRIGGER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_SIZE:  buffer_size  <= cfg_data;
        REG_POLLED_MODE:  polled_mode  <= cfg_data[0];
        REG_FIFO_TRIGGER: fifo_trigger <= cfg_data[TRIGGER_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the ring length and advance both indices with wrap
  always_comb begin
    if (buffer_size < BUF_SIZE_W'(2)) begin
      ring_len = BUF_SIZE_W'(2);
    end else if (buffer_size > QDEPTH) begin
      ring_len = QDEPTH;
    end else begin
      ring_len = buffer_size;
    end
    wr_sum = BUF_SIZE_W'(write_index) + BUF_SIZE_W'(1);
    rd_sum = BUF_SIZE_W'(read_index) + BUF_SIZE_W'(1);
    wr_adv = (wr_sum >= ring_len) ? '0 : wr_sum[IW-1:0];
    rd_adv = (rd_sum >= ring_len) ? '0 : rd_sum[IW-1:0];
  end

  // Ring occupancy, drain eligibility and burst room
  always_comb begin
    full     = (wr_adv == read_index);
    empty    = (read_index == write_index);
    drain_ok = active_flag && (level_q <= fifo_trigger);
    if (level_q >= FIFO_DEPTH) begin
      room = '0;
    end else begin
      room = COUNT_W'(FIFO_DEPTH - level_q);
    end
    if (room > MAX_BURST) begin
      room = MAX_BURST;
    end
    active_nosend = active_flag && !(drain_ok && empty);
    active_emit   = active_flag && (rd_adv != write_index);
  end

  assign store_we = cmd.commit_reply && (func_q == FUNC_PUSH) && !full;

  // Status to the controller
  always_comb begin
    status.is_push   = (func_q == FUNC_PUSH);
    status.no_send   = !drain_ok || (room == '0) || empty;
    status.slot_free = !out_valid || out_ready;
    status.fin       = (COUNT_W'(count + COUNT_W'(1)) == room) || (rd_adv == write_index);
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_q  <= func;
      data_q  <= data_byte;
      level_q <= fifo_level;
    end
  end

  // Count bytes of the current burst
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      count <= '0;
    end else if (cmd.emit_byte) begin
      count <= COUNT_W'(count + COUNT_W'(1));
    end
  end

  // Advance indices and update the active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
      active_flag <= 1'b0;
    end else if (cmd.commit_reply) begin
      if (func_q == FUNC_PUSH) begin
        active_flag <= 1'b1;
        if (!full) begin
          write_index <= wr_adv;
        end
      end else begin
        active_flag <= active_nosend;
      end
    end else if (cmd.emit_byte) begin
      read_index  <= rd_adv;
      active_flag <= active_emit;
    end
  end

  utrq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (write_index),
    .wr_data (data_q),
    .rd_en   (cmd.read_issue),
    .rd_addr (read_index),
    .rd_data (rd_data)
  );

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit_reply || cmd.emit_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load output fields
  always_ff @(posedge clk) begin
    if (cmd.commit_reply) begin
      byte_valid <= 1'b0;
      tx_byte    <= '0;
      last       <= 1'b1;
      if (func_q == FUNC_PUSH) begin
        reply_kind    <= REPLY_PUSH;
        accepted      <= !full;
        tx_active     <= 1'b1;
        tx_irq_enable <= !polled_mode;
      end else begin
        reply_kind    <= REPLY_DRAIN;
        accepted      <= 1'b0;
        tx_active     <= active_nosend;
        tx_irq_enable <= active_nosend && !polled_mode;
      end
    end else if (cmd.emit_byte) begin
      reply_kind    <= REPLY_DRAIN;
      accepted      <= 1'b0;
      byte_valid    <= 1'b1;
      tx_byte       <= rd_data;
      last          <= status.fin;
      tx_active     <= active_emit;
      tx_irq_enable <= active_emit && !polled_mode;
    end
  end

  // A push always leaves the block active
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit_reply && (func_q == FUNC_PUSH) |=> active_flag)
    else $error("push did not set active flag");

  // A push into a full ring leaves the write index alone
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit_reply && (func_q == FUNC_PUSH) && full |=> $stable(write_index))
    else $error("write index moved on full ring");

  // A sent byte is never a push answer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> (reply_kind == REPLY_DRAIN) && !accepted)
    else $error("sent byte tagged as push answer");

  // Bytes are only sent out of a non-empty ring
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit_byte |-> !empty)
    else $error("byte sent from empty ring");

endmodule

// ===== design/uart_tx_ring_queue.sv =====
// Top level of the UART transmit ring queue.
// Depends on utrq_pkg, utrq_ctrl, utrq_datapath (which holds utrq_ram).
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, data_byte and fifo_level.
//   A push (func 0) stores data_byte in the ring unless it is full and gives
//   one reply beat. A drain (func 1) reports the hardware FIFO level; when the
//   queue is active and the level is at or below fifo_trigger, it sends up to
//   eight queued bytes, one output beat each, with last on the final beat.
//   Otherwise a drain gives one empty beat with last set.
//   Configuration channel (cfg_valid/cfg_ready, ready whenever out of reset)
//   writes buffer_size, polled_mode and fifo_trigger by index; write only when idle.
//   Flow: one item at a time. A push or a drain that sends nothing loads its
//   reply beat from the decide state once the output register is free.
//   A sending drain reads each byte in the decide or read state and loads it in
//   the emit state, set by the registered read of the store; the next read waits for that load.
//   The next item is taken in the cycle after the last beat is loaded.
//   Reset clears indices and the active flag and restores register defaults;
//   store contents are undefined until written. When the receiver stalls,
//   the output register holds its beat and the controller waits.
module uart_tx_ring_queue #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               func,
  input  logic [utrq_pkg::BYTE_W-1:0]        data_byte,
  input  logic [utrq_pkg::LEVEL_W-1:0]       fifo_level,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [utrq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [utrq_pkg::CFG_DATA_W-1:0]    cfg_data,
  // output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               reply_kind,
  output logic                               accepted,
  output logic                               byte_valid,
  output logic [utrq_pkg::BYTE_W-1:0]        tx_byte,
  output logic                               last,
  output logic                               tx_active,
  output logic                               tx_irq_enable
);
  import utrq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = !rst;

  utrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  utrq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .func          (func),
    .data_byte     (data_byte),
    .fifo_level    (fifo_level),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reply_kind    (reply_kind),
    .accepted      (accepted),
    .byte_valid    (byte_valid),
    .tx_byte       (tx_byte),
    .last          (last),
    .tx_active     (tx_active),
    .tx_irq_enable (tx_irq_enable),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

// ===== sim/uart_tx_ring_queue_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for uart_tx_ring_queue: directed table, then random phases.
// Depends on utrq_pkg and the uart_tx_ring_queue RTL; the shadow ring below predicts beats.
module uart_tx_ring_queue_test;
  import utrq_pkg::*;

  localparam int RING_DEPTH   = 256;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 200000;

  // Random phases: register setting and number of items each
  localparam int N_PHASES = 7;
  localparam int PHASE_SIZE   [N_PHASES] = '{256, 5, 2, 16, 1, 300, 8};
  localparam int PHASE_POLLED [N_PHASES] = '{0, 1, 0, 1, 0, 1, 0};
  localparam int PHASE_TRIG   [N_PHASES] = '{4, 8, 0, 15, 6, 2, 7};
  localparam int PHASE_ITEMS  [N_PHASES] = '{60, 45, 30, 50, 30, 45, 40};
  localparam int QUIET_PHASE  = 2;
  localparam int HOLD_PHASE   = 3;

  typedef struct packed {
    logic              kind;
    logic              acc;
    logic              bvalid;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              active;
    logic              irq;
  } beat_t;

  typedef struct packed {
    logic                  setup;
    logic [CFG_DATA_W-1:0] size;
    logic                  polled;
    logic [TRIGGER_W-1:0]  trig;
    logic                  fn;
    logic [BYTE_W-1:0]     data;
    logic [LEVEL_W-1:0]    lvl;
    logic                  typed;
    beat_t                 want;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic [LEVEL_W-1:0] fifo_level = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic reply_kind, accepted, byte_valid, last, tx_active, tx_irq_enable;
  logic [BYTE_W-1:0] tx_byte;

  // Sideband that travels with the input beat: typed expectation for table rows
  logic row_typed = 1'b0;
  beat_t row_want = '0;

  uart_tx_ring_queue #(.QUEUE_DEPTH(RING_DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .data_byte(data_byte), .fifo_level(fifo_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .reply_kind(reply_kind), .accepted(accepted), .byte_valid(byte_valid),
    .tx_byte(tx_byte), .last(last), .tx_active(tx_active), .tx_irq_enable(tx_irq_enable)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Shadow copy of the ring, pointers and registers
  logic [BYTE_W-1:0]     shadow_mem [RING_DEPTH];
  int unsigned           shadow_rd = 0;
  int unsigned           shadow_wr = 0;
  logic                  shadow_active = 1'b0;
  logic [CFG_DATA_W-1:0] shadow_size = BUFFER_SIZE_RESET;
  logic                  shadow_polled = 1'b0;
  logic [TRIGGER_W-1:0]  shadow_trigger = FIFO_TRIGGER_RESET;

  beat_t pending_beats [$];
  int errors = 0;
  int cycle_count = 0;
  int n_push = 0, n_refused = 0, n_drain = 0, n_sent = 0, n_settings = 0;
  logic quiet = 1'b0;
  int hold_req = 0, hold_done = 0;

  function automatic int unsigned ring_length();
    int unsigned n;
    n = 32'(shadow_size);
    if (n < 2) n = 2;
    if (n > RING_DEPTH) n = RING_DEPTH;
    return n;
  endfunction

  function automatic int unsigned next_slot(int unsigned p);
    int unsigned n;
    n = p + 1;
    if (n >= ring_length()) n = 0;
    return n;
  endfunction

  function automatic beat_t make_beat(logic kind, logic acc, logic bv, logic [BYTE_W-1:0] b,
                                      logic fin);
    beat_t r;
    r.kind   = kind;
    r.acc    = acc;
    r.bvalid = bv;
    r.data   = b;
    r.last   = fin;
    r.active = shadow_active;
    r.irq    = shadow_active && !shadow_polled;
    return r;
  endfunction

  // Advance the shadow ring by one input beat and queue the beats it causes
  task automatic predict_ring_step(logic fn, logic [BYTE_W-1:0] d, logic [LEVEL_W-1:0] lvl,
                                   logic typed, beat_t want);
    beat_t beats [$];
    int unsigned nxt, room, sent;
    logic [BYTE_W-1:0] b;
    logic fin;
    if (fn == FUNC_PUSH) begin
      n_push++;
      nxt = next_slot(shadow_wr);
      fin = (nxt != shadow_rd);
      if (fin) begin
        shadow_mem[RING_AW'(shadow_wr)] = d;
        shadow_wr = nxt;
      end else begin
        n_refused++;
      end
      shadow_active = 1'b1;
      beats.push_back(make_beat(REPLY_PUSH, fin, 1'b0, '0, 1'b1));
    end else begin
      n_drain++;
      if (!shadow_active || lvl > shadow_trigger) begin
        beats.push_back(make_beat(REPLY_DRAIN, 1'b0, 1'b0, '0, 1'b1));
      end else begin
        room = (lvl >= FIFO_DEPTH) ? 0 : int'(FIFO_DEPTH) - int'(lvl);
        if (room > MAX_BURST) room = MAX_BURST;
        if (room == 0 || shadow_rd == shadow_wr) begin
          if (shadow_rd == shadow_wr) shadow_active = 1'b0;
          beats.push_back(make_beat(REPLY_DRAIN, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          sent = 0;
          while (sent < room && shadow_rd != shadow_wr) begin
            b = shadow_mem[RING_AW'(shadow_rd)];
            shadow_rd = next_slot(shadow_rd);
            fin = (sent + 1 == room) || (shadow_rd == shadow_wr);
            if (fin && shadow_rd == shadow_wr) shadow_active = 1'b0;
            beats.push_back(make_beat(REPLY_DRAIN, 1'b0, 1'b1, b, fin));
            sent++;
          end
          n_sent += sent;
        end
      end
    end
    // Table rows with a typed answer replace the predicted one
    if (typed) begin
      pending_beats.push_back(want);
    end else begin
      foreach (beats[i]) pending_beats.push_back(beats[i]);
    end
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] exp_v, logic [BYTE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Sample both channels before the edge updates them
  always @(posedge clk) begin
    beat_t e;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      shadow_rd      = 0;
      shadow_wr      = 0;
      shadow_active  = 1'b0;
      shadow_size    = BUFFER_SIZE_RESET;
      shadow_polled  = 1'b0;
      shadow_trigger = FIFO_TRIGGER_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BUFFER_SIZE:  shadow_size = cfg_data;
          REG_POLLED_MODE:  shadow_polled = cfg_data[0];
          REG_FIFO_TRIGGER: shadow_trigger = cfg_data[TRIGGER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_ring_step(func, data_byte, fifo_level, row_typed, row_want);
      if (out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected output beat, expected none, actual kind %0h byte %0h",
                   $time, reply_kind, tx_byte);
        end else begin
          e = pending_beats.pop_front();
          check_field("reply_kind", BYTE_W'(e.kind), BYTE_W'(reply_kind));
          check_field("accepted", BYTE_W'(e.acc), BYTE_W'(accepted));
          check_field("byte_valid", BYTE_W'(e.bvalid), BYTE_W'(byte_valid));
          check_field("tx_byte", e.data, tx_byte);
          check_field("last", BYTE_W'(e.last), BYTE_W'(last));
          check_field("tx_active", BYTE_W'(e.active), BYTE_W'(tx_active));
          check_field("tx_irq_enable", BYTE_W'(e.irq), BYTE_W'(tx_irq_enable));
        end
      end
    end
  end

  // Receiver: random stall per beat, one long hold-off on request
  initial begin : sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_done < hold_req) begin
        hold_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d beats outstanding", $time, cycle_count,
             pending_beats.size());
    $display("uart_tx_ring_queue_test: FAIL");
    $finish;
  end

  // Offer one input beat after a random gap; return at the accepting edge with valid held
  task automatic send_item(logic fn, logic [BYTE_W-1:0] d, logic [LEVEL_W-1:0] lvl,
                           logic typed, beat_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    data_byte  <= d;
    fifo_level <= lvl;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected beat is back, plus some slack
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Empty the ring first so the read pointer follows the write pointer after a resize
  task automatic apply_setting(logic [CFG_DATA_W-1:0] size, logic polled,
                               logic [TRIGGER_W-1:0] trig);
    settle();
    while (shadow_rd != shadow_wr) begin
      send_item(FUNC_DRAIN, '0, '0, 1'b0, '0);
      settle();
    end
    write_reg(REG_BUFFER_SIZE, size);
    write_reg(REG_POLLED_MODE, CFG_DATA_W'(polled));
    write_reg(REG_FIFO_TRIGGER, CFG_DATA_W'(trig));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  stim_row_t stim_rows [$];

  task automatic row_setup(logic [CFG_DATA_W-1:0] size, logic polled, logic [TRIGGER_W-1:0] trig);
    stim_row_t r;
    r = '0;
    r.setup  = 1'b1;
    r.size   = size;
    r.polled = polled;
    r.trig   = trig;
    stim_rows.push_back(r);
  endtask

  task automatic row_item(logic fn, logic [BYTE_W-1:0] d, logic [LEVEL_W-1:0] lvl, logic typed,
                          beat_t want);
    stim_row_t r;
    r = '0;
    r.fn    = fn;
    r.data  = d;
    r.lvl   = lvl;
    r.typed = typed;
    r.want  = want;
    stim_rows.push_back(r);
  endtask

  initial begin : stimulus
    int unsigned pick;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Reset setting: full ring length, interrupt mode, trigger at four
    row_item(FUNC_DRAIN, 8'h00, 4'd0, 1'b1, beat_t'{REPLY_DRAIN, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0});
    row_item(FUNC_PUSH, 8'h00, 4'd0, 1'b1, beat_t'{REPLY_PUSH, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1});
    row_item(FUNC_PUSH, 8'hff, 4'd15, 1'b1, beat_t'{REPLY_PUSH, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1});
    row_item(FUNC_DRAIN, 8'h00, 4'd15, 1'b1, beat_t'{REPLY_DRAIN, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1});
    row_item(FUNC_DRAIN, 8'h00, 4'd5, 1'b1, beat_t'{REPLY_DRAIN, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1});
    row_item(FUNC_DRAIN, 8'h00, 4'd4, 1'b0, '0);
    row_item(FUNC_DRAIN, 8'h00, 4'd0, 1'b1, beat_t'{REPLY_DRAIN, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0});
    row_item(FUNC_PUSH, 8'ha5, 4'd0, 1'b0, '0);
    row_item(FUNC_PUSH, 8'h5a, 4'd0, 1'b0, '0);
    row_item(FUNC_PUSH, 8'h3c, 4'd0, 1'b0, '0);
    row_item(FUNC_PUSH, 8'h96, 4'd0, 1'b0, '0);
    // A level above the trigger sends nothing, then a drain sends all four queued bytes
    row_item(FUNC_DRAIN, 8'h00, 4'd7, 1'b0, '0);
    row_item(FUNC_DRAIN, 8'h00, 4'd0, 1'b0, '0);
    // Shrink below the pointers, polled mode, trigger at the FIFO depth
    row_setup(9'd2, 1'b1, 4'd8);
    row_item(FUNC_PUSH, 8'h11, 4'd0, 1'b1, beat_t'{REPLY_PUSH, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0});
    row_item(FUNC_PUSH, 8'h22, 4'd0, 1'b0, '0);
    row_item(FUNC_DRAIN, 8'h00, 4'd8, 1'b1, beat_t'{REPLY_DRAIN, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0});
    row_item(FUNC_DRAIN, 8'h00, 4'd15, 1'b1, beat_t'{REPLY_DRAIN, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0});
    row_item(FUNC_DRAIN, 8'h00, 4'd0, 1'b0, '0);
    // Size below range acts as two: second push finds the ring full
    row_setup(9'd0, 1'b0, 4'd0);
    row_item(FUNC_PUSH, 8'h33, 4'd0, 1'b0, '0);
    row_item(FUNC_PUSH, 8'h44, 4'd0, 1'b1, beat_t'{REPLY_PUSH, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1});
    row_item(FUNC_DRAIN, 8'h00, 4'd1, 1'b1, beat_t'{REPLY_DRAIN, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1});
    row_item(FUNC_DRAIN, 8'h00, 4'd0, 1'b0, '0);
    // Size above range, trigger at its top: a full FIFO sends nothing
    row_setup(9'd511, 1'b0, 4'd15);
    row_item(FUNC_PUSH, 8'h7e, 4'd0, 1'b0, '0);
    row_item(FUNC_DRAIN, 8'h00, 4'd12, 1'b1, beat_t'{REPLY_DRAIN, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1});
    row_item(FUNC_DRAIN, 8'h00, 4'd0, 1'b0, '0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].setup)
        apply_setting(stim_rows[i].size, stim_rows[i].polled, stim_rows[i].trig);
      else
        send_item(stim_rows[i].fn, stim_rows[i].data, stim_rows[i].lvl, stim_rows[i].typed,
                  stim_rows[i].want);
    end

    // Random phases: mostly pushes and drains at or under the trigger, some noise levels
    for (int ph = 0; ph < N_PHASES; ph++) begin
      apply_setting(CFG_DATA_W'(PHASE_SIZE[ph]), PHASE_POLLED[ph] != 0,
                    TRIGGER_W'(PHASE_TRIG[ph]));
      quiet = (ph == QUIET_PHASE);
      if (ph == HOLD_PHASE) hold_req++;
      repeat (PHASE_ITEMS[ph]) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          send_item(FUNC_PUSH, 8'($urandom), 4'($urandom), 1'b0, '0);
        else if (pick < 85)
          send_item(FUNC_DRAIN, 8'($urandom), 4'($urandom_range(0, PHASE_TRIG[ph])), 1'b0, '0);
        else
          send_item(FUNC_DRAIN, 8'($urandom), 4'($urandom_range(0, 15)), 1'b0, '0);
      end
      quiet = 1'b0;
    end
    settle();

    $display("Run covered %0d pushes (%0d refused on a full ring) and %0d drains sending %0d bytes,",
             n_push, n_refused, n_drain, n_sent);
    $display("across %0d register settings in %0d cycles; %0d field mismatches.",
             n_settings, cycle_count, errors);
    if (errors == 0) begin
      $display("uart_tx_ring_queue_test: PASS");
    end else begin
      $display("uart_tx_ring_queue_test: FAIL");
    end
    $finish;
  end

endmodule
